[hw/rtl/adv_uuid_filter_best_rssi_assert.svh]
// Assertion macros shared by the checker of the advertising UUID filter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ADV_UUID_FILTER_BEST_RSSI_ASSERT_SVH
`define ADV_UUID_FILTER_BEST_RSSI_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AUFBR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AUFBR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/aufbr_pkg.sv]
// Shared types and constants of the advertising UUID filter.
// Used by the front queue, the back executor, the top level and the checker.
package aufbr_pkg;

	// Device table size and the widths derived from it.
	localparam int MAX_DEVICES = 10;
	localparam int CNT_W = $clog2(MAX_DEVICES + 1);
	localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEVICES);

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// UUID chunk handling.
	localparam int CHUNK_BYTES = 16;
	localparam logic [3:0] CHUNK_LAST = 4'(CHUNK_BYTES - 1);
	localparam logic [7:0] AD_TYPE_UUID128 = 8'h07;
	localparam logic [2:0] ADV_CONN_UNDIRECTED = 3'd0;

	// Stream widths.
	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 64;

	// Configuration register indexes.
	localparam logic REG_UUID_LOW = 1'b0;
	localparam logic REG_UUID_HIGH = 1'b1;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_SELECT = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_RECORDED = 3'd0,
		ST_NOMATCH = 3'd1,
		ST_IGNORED = 3'd2,
		ST_MALFORMED = 3'd3,
		ST_SELECTED = 3'd4,
		ST_NONE = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_LEN = 2'd0,
		PH_TYPE = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [0:0] {
		BK_RUN = 1'b0,
		BK_SCAN = 1'b1
	} back_state_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] ad_byte;
		logic [4:0] report_length;
		logic last_byte;
		logic [2:0] adv_type;
		logic [7:0] rssi;
		logic [47:0] dev_addr;
		logic dev_addr_type;
	} item_t;

	// Head of the queue as seen by the back part.
	typedef struct packed {
		logic valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [7:0] rssi;
		logic [47:0] addr;
		logic addr_type;
	} entry_t;

	typedef struct packed {
		status_t status;
		logic [47:0] best_addr;
		logic best_addr_type;
		logic [7:0] best_rssi;
		logic [3:0] device_count;
	} result_t;

	// Per-report parser state.
	typedef struct packed {
		phase_t phase;
		logic [4:0] left;
		logic [4:0] consumed;
		logic [3:0] chunk_pos;
		logic chunk_eq;
		logic uuid_act;
		logic finished;
		status_t outcome;
	} parse_t;

	localparam parse_t PARSE_RESET = '{
		phase: PH_LEN,
		left: 5'd0,
		consumed: 5'd0,
		chunk_pos: 4'd0,
		chunk_eq: 1'b1,
		uuid_act: 1'b0,
		finished: 1'b0,
		outcome: ST_NOMATCH
	};

endpackage

[hw/rtl/adv_uuid_filter_best_rssi.sv]
// Advertising UUID filter, top level. A payload byte, clear or empty select
// gives its result from the output register after passing through the queue; one byte per cycle
// is sustained while the output is not stalled. A select on a non-empty table scans the table
// memory one entry per cycle and then answers, holding later items in the queue meanwhile.
// Reset (arst_n low) empties the table, restarts the parser and zeroes the UUID.
module adv_uuid_filter_best_rssi (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ad_byte[7:0], report_length[12:8], adv_type[15:13], rssi[23:16],
	// dev_addr[71:24], dev_addr_type[72], zero fill above
	input  logic [aufbr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0] s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// best_addr[47:0], best_addr_type[48], best_rssi[56:49], device_count[60:57],
	// zero fill above
	output logic [aufbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0] m_axis_tuser
);

	aufbr_pkg::qhead_t head;
	logic pop;
	aufbr_pkg::result_t result;

	aufbr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.head(head),
		.pop(pop)
	);

	aufbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.head(head),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.result(result)
	);

	// Pack the result transfer.
	assign m_axis_tdata = {3'b000, result.device_count, result.best_rssi,
		result.best_addr_type, result.best_addr};
	assign m_axis_tuser = result.status;

endmodule

[hw/rtl/aufbr_front.sv]
// Front part of the advertising UUID filter: accepts stream transfers,
// decodes them into items and holds them in a short queue. Uses aufbr_pkg.
module aufbr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ad_byte[7:0], report_length[12:8], adv_type[15:13], rssi[23:16],
	// dev_addr[71:24], dev_addr_type[72], zero fill above
	input  logic [aufbr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0] s_axis_tuser,
	input  logic s_axis_tlast,
	output aufbr_pkg::qhead_t head,
	input  logic pop
);

	aufbr_pkg::item_t mem_q [aufbr_pkg::QUEUE_DEPTH];
	logic [aufbr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [aufbr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [aufbr_pkg::QCNT_W-1:0] cnt_q;
	aufbr_pkg::item_t in_item;
	logic push;
	logic do_pop;

	// Unpack the transfer into item fields.
	always_comb begin
		in_item.kind = aufbr_pkg::kind_t'(s_axis_tuser);
		in_item.ad_byte = s_axis_tdata[7:0];
		in_item.report_length = s_axis_tdata[12:8];
		in_item.last_byte = s_axis_tlast;
		in_item.adv_type = s_axis_tdata[15:13];
		in_item.rssi = s_axis_tdata[23:16];
		in_item.dev_addr = s_axis_tdata[71:24];
		in_item.dev_addr_type = s_axis_tdata[72];
	end

	// Unused kind codes are taken and dropped here; they never reach the back.
	assign s_axis_tready = (cnt_q != aufbr_pkg::QCNT_W'(aufbr_pkg::QUEUE_DEPTH));
	assign push = s_axis_tvalid && s_axis_tready && (in_item.kind != aufbr_pkg::KIND_UNUSED);
	assign do_pop = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == aufbr_pkg::QPTR_W'(aufbr_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == aufbr_pkg::QPTR_W'(aufbr_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/aufbr_back.sv]
// Back part of the advertising UUID filter: LTV parser, device table memory,
// strongest-entry scan and the output register. Uses aufbr_pkg.
module aufbr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [63:0] cfg_wdata,
	input  aufbr_pkg::qhead_t head,
	output logic pop,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output aufbr_pkg::result_t result
);

	logic [63:0] uuid_low_q;
	logic [63:0] uuid_high_q;
	aufbr_pkg::back_state_t state_q;
	aufbr_pkg::back_state_t state_n;
	aufbr_pkg::parse_t prs_q;
	aufbr_pkg::parse_t prs_n;
	logic [aufbr_pkg::CNT_W-1:0] count_q;
	logic [aufbr_pkg::CNT_W-1:0] count_n;
	aufbr_pkg::entry_t mem_q [aufbr_pkg::MAX_DEVICES];
	logic [aufbr_pkg::CNT_W-1:0] rd_idx_q;
	logic rd_vld_q;
	logic rd_first_q;
	aufbr_pkg::entry_t rd_data_q;
	aufbr_pkg::entry_t best_q;
	logic out_valid_q;
	aufbr_pkg::result_t out_q;
	logic out_free;
	logic scan_rd;
	logic scan_done;
	logic record;
	logic pop_clear;
	logic pop_byte;
	logic pop_select;
	logic emit;
	aufbr_pkg::result_t emit_res;
	aufbr_pkg::item_t it;
	logic [127:0] uuid_all;
	logic [7:0] uuid_b;

	assign it = head.item;
	assign uuid_all = {uuid_high_q, uuid_low_q};
	assign uuid_b = uuid_all[{prs_q.chunk_pos, 3'b000} +: 8];
	assign out_free = !out_valid_q || m_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uuid_low_q <= '0;
			uuid_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aufbr_pkg::REG_UUID_LOW: uuid_low_q <= cfg_wdata;
				aufbr_pkg::REG_UUID_HIGH: uuid_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Scan sequencer: next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			aufbr_pkg::BK_RUN: begin
				if (head.valid && out_free && (it.kind == aufbr_pkg::KIND_SELECT)
						&& (count_q != '0)) begin
					state_n = aufbr_pkg::BK_SCAN;
				end
			end
			aufbr_pkg::BK_SCAN: begin
				if ((rd_idx_q == count_q) && !rd_vld_q) begin
					state_n = aufbr_pkg::BK_RUN;
				end
			end
			default: state_n = aufbr_pkg::BK_RUN;
		endcase
	end

	// Scan sequencer: outputs.
	always_comb begin
		pop = 1'b0;
		scan_rd = 1'b0;
		scan_done = 1'b0;
		unique case (state_q)
			aufbr_pkg::BK_RUN: pop = head.valid && out_free;
			aufbr_pkg::BK_SCAN: begin
				scan_rd = (rd_idx_q < count_q);
				scan_done = (rd_idx_q == count_q) && !rd_vld_q;
			end
			default: ;
		endcase
	end

	assign pop_clear = pop && (it.kind == aufbr_pkg::KIND_CLEAR);
	assign pop_byte = pop && (it.kind == aufbr_pkg::KIND_BYTE);
	assign pop_select = pop && (it.kind == aufbr_pkg::KIND_SELECT);

	// Parser step for one payload byte.
	always_comb begin
		logic [4:0] left;
		logic [4:0] left_dec;
		logic eq_n;
		logic stop;
		prs_n = prs_q;
		record = 1'b0;
		stop = 1'b0;
		eq_n = 1'b0;
		left = (prs_q.consumed < it.report_length) ? (it.report_length - prs_q.consumed) : 5'd0;
		left_dec = prs_q.left - 5'd1;
		if (prs_q.consumed != 5'd31) begin
			prs_n.consumed = prs_q.consumed + 5'd1;
		end
		// Eligibility is judged on the first byte of a report.
		if ((prs_q.consumed == 5'd0) && ((it.adv_type != aufbr_pkg::ADV_CONN_UNDIRECTED)
				|| (count_q >= aufbr_pkg::MAX_CNT))) begin
			prs_n.finished = 1'b1;
			prs_n.outcome = aufbr_pkg::ST_IGNORED;
		end else if (!prs_q.finished) begin
			unique case (prs_q.phase)
				aufbr_pkg::PH_LEN: begin
					if (left <= 5'd1) begin
						prs_n.finished = 1'b1;
						prs_n.outcome = aufbr_pkg::ST_NOMATCH;
					end else if (it.ad_byte == 8'd0) begin
						prs_n.finished = 1'b1;
						prs_n.outcome = aufbr_pkg::ST_NOMATCH;
					end else if (it.ad_byte > ({3'b000, left} - 8'd1)) begin
						prs_n.finished = 1'b1;
						prs_n.outcome = aufbr_pkg::ST_MALFORMED;
					end else begin
						prs_n.left = it.ad_byte[4:0];
						prs_n.phase = aufbr_pkg::PH_TYPE;
					end
				end
				aufbr_pkg::PH_TYPE: begin
					prs_n.uuid_act = (it.ad_byte == aufbr_pkg::AD_TYPE_UUID128);
					prs_n.left = left_dec;
					prs_n.chunk_pos = 4'd0;
					prs_n.chunk_eq = 1'b1;
					prs_n.phase = (left_dec == 5'd0) ? aufbr_pkg::PH_LEN : aufbr_pkg::PH_DATA;
				end
				aufbr_pkg::PH_DATA: begin
					if (prs_q.uuid_act) begin
						eq_n = prs_q.chunk_eq && (it.ad_byte == uuid_b);
						if (prs_q.chunk_pos == aufbr_pkg::CHUNK_LAST) begin
							if (eq_n && (count_q < aufbr_pkg::MAX_CNT)) begin
								record = 1'b1;
								stop = 1'b1;
								prs_n.finished = 1'b1;
								prs_n.outcome = aufbr_pkg::ST_RECORDED;
							end else begin
								prs_n.chunk_pos = 4'd0;
								prs_n.chunk_eq = 1'b1;
							end
						end else begin
							prs_n.chunk_pos = prs_q.chunk_pos + 4'd1;
							prs_n.chunk_eq = eq_n;
						end
					end
					// A recorded match leaves the remaining field count untouched.
					if (!stop) begin
						if (prs_q.left != 5'd0) begin
							prs_n.left = left_dec;
							if (left_dec == 5'd0) begin
								prs_n.phase = aufbr_pkg::PH_LEN;
							end
						end else begin
							prs_n.phase = aufbr_pkg::PH_LEN;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Table count after the popped item.
	always_comb begin
		count_n = count_q;
		if (pop_clear) begin
			count_n = '0;
		end else if (pop_byte && record) begin
			count_n = count_q + 1'b1;
		end
	end

	// Result produced by the popped item or by the end of a scan.
	always_comb begin
		emit = 1'b0;
		emit_res.status = aufbr_pkg::ST_NOMATCH;
		emit_res.best_addr = '0;
		emit_res.best_addr_type = 1'b0;
		emit_res.best_rssi = '0;
		emit_res.device_count = 4'(count_n);
		if (scan_done) begin
			emit = 1'b1;
			emit_res.status = aufbr_pkg::ST_SELECTED;
			emit_res.best_addr = best_q.addr;
			emit_res.best_addr_type = best_q.addr_type;
			emit_res.best_rssi = best_q.rssi;
		end else if (pop_clear) begin
			emit = 1'b1;
			emit_res.status = aufbr_pkg::ST_CLEARED;
		end else if (pop_byte && it.last_byte) begin
			emit = 1'b1;
			emit_res.status = prs_n.finished ? prs_n.outcome : aufbr_pkg::ST_NOMATCH;
		end else if (pop_select && (count_q == '0)) begin
			emit = 1'b1;
			emit_res.status = aufbr_pkg::ST_NONE;
		end
	end

	// Control state: sequencer, parser, table count, scan flags, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aufbr_pkg::BK_RUN;
			prs_q <= aufbr_pkg::PARSE_RESET;
			count_q <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			rd_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (pop_clear) begin
				prs_q <= aufbr_pkg::PARSE_RESET;
			end else if (pop_byte) begin
				prs_q <= it.last_byte ? aufbr_pkg::PARSE_RESET : prs_n;
			end
			if (pop_select) begin
				rd_idx_q <= '0;
				rd_vld_q <= 1'b0;
			end else if (state_q == aufbr_pkg::BK_SCAN) begin
				rd_vld_q <= scan_rd;
				rd_first_q <= (rd_idx_q == '0);
				if (scan_rd) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Device table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (pop_byte && record) begin
			mem_q[count_q[aufbr_pkg::IDX_W-1:0]] <= '{rssi: it.rssi, addr: it.dev_addr,
				addr_type: it.dev_addr_type};
		end
		if (scan_rd) begin
			rd_data_q <= mem_q[rd_idx_q[aufbr_pkg::IDX_W-1:0]];
		end
	end

	// Best entry so far; ties keep the earlier entry.
	always_ff @(posedge clk) begin
		if (rd_vld_q && (rd_first_q || ($signed(rd_data_q.rssi) > $signed(best_q.rssi)))) begin
			best_q <= rd_data_q;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign result = out_q;

endmodule

[hw/rtl/aufbr_chk.sv]
// Port-level checker of the advertising UUID filter, bound to the top level.
// Uses aufbr_pkg and the assertion macros header.
`include "adv_uuid_filter_best_rssi_assert.svh"

module aufbr_chk (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [aufbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);

	// A stalled result transfer keeps its contents.
	`AUFBR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// Only a selection carries device fields.
	`AUFBR_ASSERT_IMP(a_fields_zero, m_axis_tvalid && (m_axis_tuser != aufbr_pkg::ST_SELECTED), m_axis_tdata[56:0] == 57'd0, "device fields set without selection")

	// An empty-table answer and a clear both report zero devices.
	`AUFBR_ASSERT_IMP(a_empty_count, m_axis_tvalid && ((m_axis_tuser == aufbr_pkg::ST_NONE) || (m_axis_tuser == aufbr_pkg::ST_CLEARED)), m_axis_tdata[60:57] == 4'd0, "empty table with nonzero count")

	// A selection or a fresh record implies a populated table.
	`AUFBR_ASSERT_IMP(a_sel_count, m_axis_tvalid && ((m_axis_tuser == aufbr_pkg::ST_SELECTED) || (m_axis_tuser == aufbr_pkg::ST_RECORDED)), m_axis_tdata[60:57] != 4'd0, "table entry reported with zero count")

endmodule

bind adv_uuid_filter_best_rssi aufbr_chk u_chk (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the advertising UUID filter: drives reports, clears and
// selects over the input stream and checks every result against its own tracker.
// Depends only on aufbr_pkg and the adv_uuid_filter_best_rssi top level.
module tb;
	import aufbr_pkg::*;

	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 320;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORT = 31;

	typedef enum logic [1:0] {
		LTV_LEN,
		LTV_TYPE,
		LTV_DATA
	} ltv_step_t;

	// Clock, reset and block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// ad_byte[7:0], report_length[12:8], adv_type[15:13], rssi[23:16],
	// dev_addr[71:24], dev_addr_type[72], zero fill above
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	// kind[1:0]
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// best_addr[47:0], best_addr_type[48], best_rssi[56:49], device_count[60:57],
	// zero fill above
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// status[2:0]
	logic [2:0] m_axis_tuser;

	// Tracker state: configured UUID, per-report parse state and device table.
	logic [63:0] uuid_lo = '0;
	logic [63:0] uuid_hi = '0;
	ltv_step_t ltv_step = LTV_LEN;
	int field_left = 0;
	int bytes_seen = 0;
	int chunk_idx = 0;
	bit chunk_ok = 1'b1;
	bit in_uuid_field = 1'b0;
	bit verdict_set = 1'b0;
	status_t verdict = ST_NOMATCH;
	logic [7:0] dev_rssi [MAX_DEVICES];
	logic [47:0] dev_addr_tbl [MAX_DEVICES];
	logic dev_atype [MAX_DEVICES];
	int dev_count = 0;

	// Pending input transfers and results still to arrive.
	item_t items_to_send[$];
	result_t reports_due[$];
	logic [7:0] payload[$];

	// Driver, monitor and run bookkeeping.
	item_t cur_item;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_taken = 0;
	bit sender_quiet = 1'b0;
	bit receiver_quiet = 1'b0;
	int queued_total = 0;
	int items_sent = 0;
	int results_checked = 0;
	int errors = 0;
	int full_hits = 0;
	int status_seen [8];
	int idle_cycles = 0;
	int phase_idx;
	logic [63:0] lo_val;
	logic [63:0] hi_val;

	adv_uuid_filter_best_rssi u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Per-report state goes back to the start of a report.
	function automatic void start_report();
		ltv_step = LTV_LEN;
		field_left = 0;
		bytes_seen = 0;
		chunk_idx = 0;
		chunk_ok = 1'b1;
		in_uuid_field = 1'b0;
		verdict_set = 1'b0;
		verdict = ST_NOMATCH;
	endfunction

	function automatic void conclude(status_t s);
		verdict_set = 1'b1;
		verdict = s;
	endfunction

	// UUID byte at a chunk position, in air order.
	function automatic logic [7:0] uuid_at(int pos);
		if (pos < 8) begin
			return uuid_lo[8*pos +: 8];
		end
		return uuid_hi[8*(pos-8) +: 8];
	endfunction

	// One payload byte through the length-type-value walk.
	function automatic void parse_byte(item_t it);
		int pos;
		int left;
		int b;
		b = it.ad_byte;
		pos = bytes_seen;
		left = (pos < it.report_length) ? it.report_length - pos : 0;
		if (bytes_seen < MAX_REPORT) begin
			bytes_seen++;
		end
		// Eligibility is decided on the first byte only.
		if (pos == 0 && (it.adv_type != ADV_CONN_UNDIRECTED || dev_count >= MAX_DEVICES)) begin
			if (it.adv_type == ADV_CONN_UNDIRECTED) begin
				full_hits++;
			end
			conclude(ST_IGNORED);
			return;
		end
		if (verdict_set) begin
			return;
		end
		case (ltv_step)
			LTV_LEN: begin
				if (left <= 1 || b == 0) begin
					conclude(ST_NOMATCH);
				end else if (b > left - 1) begin
					conclude(ST_MALFORMED);
				end else begin
					field_left = b;
					ltv_step = LTV_TYPE;
				end
			end
			LTV_TYPE: begin
				in_uuid_field = (b == AD_TYPE_UUID128);
				field_left = (field_left - 1) & 31;
				chunk_idx = 0;
				chunk_ok = 1'b1;
				ltv_step = (field_left == 0) ? LTV_LEN : LTV_DATA;
			end
			default: begin
				if (in_uuid_field) begin
					if (b != uuid_at(chunk_idx)) begin
						chunk_ok = 1'b0;
					end
					chunk_idx++;
					// A whole chunk has been compared.
					if (chunk_idx >= CHUNK_BYTES) begin
						if (chunk_ok && dev_count < MAX_DEVICES) begin
							dev_rssi[dev_count] = it.rssi;
							dev_addr_tbl[dev_count] = it.dev_addr;
							dev_atype[dev_count] = it.dev_addr_type;
							dev_count++;
							conclude(ST_RECORDED);
							return;
						end
						chunk_idx = 0;
						chunk_ok = 1'b1;
					end
				end
				if (field_left > 0) begin
					field_left--;
				end
				if (field_left == 0) begin
					ltv_step = LTV_LEN;
				end
			end
		endcase
	endfunction

	// Works out the result, if any, of one accepted input transfer.
	function automatic void track_item(item_t it);
		result_t r;
		int best;
		int i;
		r = '0;
		case (it.kind)
			KIND_CLEAR: begin
				dev_count = 0;
				start_report();
				r.status = ST_CLEARED;
			end
			KIND_BYTE: begin
				parse_byte(it);
				if (!it.last_byte) begin
					return;
				end
				r.status = verdict_set ? verdict : ST_NOMATCH;
				start_report();
			end
			KIND_SELECT: begin
				if (dev_count == 0) begin
					r.status = ST_NONE;
				end else begin
					// Strongest entry; the earliest one wins a tie.
					best = 0;
					for (i = 1; i < dev_count; i++) begin
						if ($signed(dev_rssi[i]) > $signed(dev_rssi[best])) begin
							best = i;
						end
					end
					r.best_addr = dev_addr_tbl[best];
					r.best_addr_type = dev_atype[best];
					r.best_rssi = dev_rssi[best];
					r.status = ST_SELECTED;
				end
			end
			default: begin
				return;
			end
		endcase
		r.device_count = 4'(dev_count);
		reports_due.push_back(r);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_item(item_t it);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[7:0] = it.ad_byte;
		d[12:8] = it.report_length;
		d[15:13] = it.adv_type;
		d[23:16] = it.rssi;
		d[71:24] = it.dev_addr;
		d[72] = it.dev_addr_type;
		return d;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [47:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// A cluster of nearby values makes RSSI ties common.
	function automatic logic [7:0] pick_rssi();
		if ($urandom_range(0, 1) == 1) begin
			return 8'($urandom);
		end
		return 8'(196 + $urandom_range(0, 3));
	endfunction

	function automatic logic [7:0] other_type();
		logic [7:0] t;
		t = 8'($urandom);
		if (t == AD_TYPE_UUID128) begin
			t = 8'hFF;
		end
		return t;
	endfunction

	function automatic item_t any_item();
		item_t it;
		it.kind = kind_t'($urandom_range(0, 2));
		it.ad_byte = 8'($urandom);
		it.report_length = 5'($urandom);
		it.last_byte = 1'($urandom);
		it.adv_type = 3'($urandom_range(0, 4));
		it.rssi = pick_rssi();
		it.dev_addr = rand_addr();
		it.dev_addr_type = 1'($urandom);
		return it;
	endfunction

	function automatic void push_item(item_t it);
		items_to_send.push_back(it);
		queued_total++;
	endfunction

	function automatic void push_ctrl(kind_t k);
		item_t it;
		it = any_item();
		it.kind = k;
		push_item(it);
	endfunction

	function automatic void add_field(logic [7:0] ftype, int dlen);
		payload.push_back(8'(dlen + 1));
		payload.push_back(ftype);
		repeat (dlen) payload.push_back(8'($urandom));
	endfunction

	// A complete-128-bit-UUID field, optionally with one bit of the UUID spoiled.
	function automatic void add_uuid_field(int extra, bit spoil);
		int k;
		int i;
		k = $urandom_range(0, 15);
		payload.push_back(8'(CHUNK_BYTES + 1 + extra));
		payload.push_back(AD_TYPE_UUID128);
		for (i = 0; i < CHUNK_BYTES; i++) begin
			if (spoil && i == k) begin
				payload.push_back(uuid_at(i) ^ (8'h01 << $urandom_range(0, 7)));
			end else begin
				payload.push_back(uuid_at(i));
			end
		end
		repeat (extra) payload.push_back(8'($urandom));
	endfunction

	function automatic void add_random_fields();
		int n;
		int cnt;
		int room;
		cnt = $urandom_range(1, 4);
		for (n = 0; n < cnt && payload.size() <= MAX_REPORT - 2; n++) begin
			room = MAX_REPORT - 2 - payload.size();
			add_field(($urandom_range(0, 3) == 0) ? AD_TYPE_UUID128 : other_type(),
				$urandom_range(0, (room > 16) ? 16 : room));
		end
	endfunction

	function automatic void fill_payload(int target);
		while (payload.size() < target) begin
			payload.push_back(8'($urandom));
		end
	endfunction

	// Sends the payload as one report; a loose report varies the side fields per byte.
	function automatic void queue_report(int rlen, int nsend, logic [2:0] adv, bit vary,
			logic [7:0] rssi, logic [47:0] addr, logic atype);
		item_t it;
		int i;
		for (i = 0; i < nsend; i++) begin
			it = any_item();
			it.kind = KIND_BYTE;
			it.ad_byte = (i < payload.size()) ? payload[i] : 8'($urandom);
			it.last_byte = (i == nsend - 1);
			if (!vary || $urandom_range(0, 7) != 0) begin
				it.report_length = 5'(rlen);
			end
			if (i == 0 || !vary) begin
				it.adv_type = adv;
			end
			if (!vary || $urandom_range(0, 2) != 0) begin
				it.rssi = rssi;
				it.dev_addr = addr;
				it.dev_addr_type = atype;
			end
			push_item(it);
		end
	endfunction

	// A run of unrelated bytes, sometimes with no closing byte.
	function automatic void push_noise();
		item_t it;
		int n;
		int i;
		bit closed;
		n = $urandom_range(1, 40);
		closed = ($urandom_range(0, 3) != 0);
		for (i = 0; i < n; i++) begin
			it = any_item();
			it.kind = KIND_BYTE;
			it.last_byte = closed && (i == n - 1);
			push_item(it);
		end
	endfunction

	// One report, mostly well formed around the UUID, the rest broken in various ways.
	function automatic void add_report();
		int t;
		int rlen;
		int nsend;
		int target;
		logic [2:0] adv;
		bit vary;
		payload.delete();
		t = $urandom_range(0, 99);
		adv = ADV_CONN_UNDIRECTED;
		vary = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 1) == 1) begin
			add_field(other_type(), $urandom_range(0, 3));
		end
		if (t < 58) begin
			add_uuid_field($urandom_range(0, MAX_REPORT - 18 - payload.size()), t >= 45);
		end else if (t < 68) begin
			add_random_fields();
		end else if (t < 74) begin
			// Length byte that runs past the end of the report.
			target = $urandom_range(payload.size() + 2, MAX_REPORT);
			payload.push_back(8'($urandom_range(target - payload.size(), 255)));
			fill_payload(target);
		end else if (t < 80) begin
			payload.push_back(8'h00);
			fill_payload($urandom_range(payload.size(), MAX_REPORT));
		end else if (t < 86) begin
			add_random_fields();
			payload.push_back(8'($urandom));
		end else begin
			add_uuid_field(0, 1'b0);
		end
		if (payload.size() == 0) begin
			payload.push_back(8'($urandom));
		end
		rlen = payload.size();
		nsend = rlen;
		if (t >= 86 && t < 90) begin
			nsend = $urandom_range(1, rlen - 1);
		end else if (t >= 90 && t < 95) begin
			adv = 3'($urandom_range(1, 4));
		end else if (t >= 95) begin
			rlen = $urandom_range(0, MAX_REPORT);
			nsend = $urandom_range(1, 40);
		end
		queue_report(rlen, nsend, adv, vary, pick_rssi(), rand_addr(), 1'($urandom));
	endfunction

	function automatic void add_traffic(int n);
		int start;
		int r;
		start = queued_total;
		while (queued_total - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				push_ctrl(KIND_CLEAR);
			end else if (r < 9) begin
				push_ctrl(KIND_SELECT);
			end else if (r < 10) begin
				push_ctrl(KIND_UNUSED);
			end else if (r < 12) begin
				push_noise();
			end else begin
				add_report();
			end
		end
	endfunction

	// Empty select, unused kind, each way a report ends, then one record, a select and a clear.
	function automatic void queue_directed();
		push_ctrl(KIND_SELECT);
		push_ctrl(KIND_UNUSED);
		payload.delete();
		payload.push_back(8'h00);
		queue_report(2, 1, ADV_CONN_UNDIRECTED, 1'b0, 8'h80, 48'h0, 1'b0);
		payload.delete();
		payload.push_back(8'hFF);
		queue_report(31, 1, ADV_CONN_UNDIRECTED, 1'b0, 8'h7F, '1, 1'b1);
		payload.delete();
		payload.push_back(8'h02);
		queue_report(31, 1, 3'd4, 1'b0, 8'h80, '1, 1'b0);
		payload.delete();
		payload.push_back(8'h05);
		queue_report(0, 1, ADV_CONN_UNDIRECTED, 1'b0, 8'h00, 48'h0, 1'b1);
		payload.delete();
		payload.push_back(8'h02);
		payload.push_back(8'h01);
		queue_report(3, 2, ADV_CONN_UNDIRECTED, 1'b0, 8'h10, rand_addr(), 1'b0);
		payload.delete();
		add_uuid_field(0, 1'b0);
		queue_report(18, 18, ADV_CONN_UNDIRECTED, 1'b0, 8'h7F, '1, 1'b1);
		push_ctrl(KIND_SELECT);
		push_ctrl(KIND_CLEAR);
	endfunction

	// Compares one result transfer with the oldest expectation.
	function automatic void check_report();
		result_t got;
		result_t want;
		got = '0;
		got.status = status_t'(m_axis_tuser);
		got.best_addr = m_axis_tdata[47:0];
		got.best_addr_type = m_axis_tdata[48];
		got.best_rssi = m_axis_tdata[56:49];
		got.device_count = m_axis_tdata[60:57];
		results_checked++;
		status_seen[m_axis_tuser]++;
		if (reports_due.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected result transfer: status %0d count %0d",
					got.status, got.device_count);
			end
			return;
		end
		want = reports_due.pop_front();
		if (got.status != want.status || got.best_addr != want.best_addr ||
				got.best_addr_type != want.best_addr_type ||
				got.best_rssi != want.best_rssi ||
				got.device_count != want.device_count) begin
			errors++;
			if (errors <= 10) begin
				$display("result %0d: expected status %0d addr %h type %0d rssi %0d count %0d",
					results_checked, want.status, want.best_addr, want.best_addr_type,
					$signed(want.best_rssi), want.device_count);
				$display("result %0d: actual   status %0d addr %h type %0d rssi %0d count %0d",
					results_checked, got.status, got.best_addr, got.best_addr_type,
					$signed(got.best_rssi), got.device_count);
			end
		end
	endfunction

	// Input driver: offers queued items, with random gaps after each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_item(cur_item);
				items_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Hold the offered item until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (items_to_send.size() > 0) begin
				cur_item = items_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pack_item(cur_item);
				s_axis_tuser <= cur_item.kind;
				s_axis_tlast <= cur_item.last_byte;
				send_gap = sender_quiet ? 0 : draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_report();
			end
			if (hold_req != hold_taken) begin
				hold_taken = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = receiver_quiet ? 0 : draw_gap();
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_uuid(logic idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_UUID_LOW) begin
			uuid_lo = value;
		end else begin
			uuid_hi = value;
		end
	endtask

	// Waits until every item is sent and every result is in, then lets the block settle.
	task automatic wait_drained();
		while (items_to_send.size() != 0 || s_axis_tvalid || reports_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sequence of phases, each with its own UUID and idling pattern.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
			sender_quiet = 1'b0;
			receiver_quiet = 1'b0;
			lo_val = {$urandom, $urandom};
			hi_val = {$urandom, $urandom};
			case (phase_idx)
				1: begin
					lo_val = '0;
					hi_val = '0;
					sender_quiet = 1'b1;
					receiver_quiet = 1'b1;
				end
				2: begin
					lo_val = '1;
					hi_val = '1;
					sender_quiet = 1'b1;
				end
				4: begin
					lo_val = '1;
					hi_val = '0;
				end
				default: begin
				end
			endcase
			write_uuid(REG_UUID_LOW, lo_val);
			write_uuid(REG_UUID_HIGH, hi_val);
			// Output held off for a long stretch while input keeps coming.
			if (phase_idx == 2) begin
				@(posedge clk);
				hold_req <= hold_req + 1;
			end
			@(negedge clk);
			if (phase_idx == 0) begin
				queue_directed();
			end
			add_traffic(ITEMS_PER_PHASE);
			wait_drained();
		end
		$display("Run covered %0d input transfers over %0d UUID settings, %0d results checked.",
			items_sent, NUM_PHASES, results_checked);
		$display("Outcomes: %0d recorded, %0d no match, %0d ignored (%0d table full), %0d malformed, %0d selected, %0d empty, %0d cleared.",
			status_seen[ST_RECORDED], status_seen[ST_NOMATCH], status_seen[ST_IGNORED], full_hits,
			status_seen[ST_MALFORMED], status_seen[ST_SELECTED], status_seen[ST_NONE],
			status_seen[ST_CLEARED]);
		if (errors == 0 && reports_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
